// ----- src/udrj_pkg.sv -----
// Shared angle constants, CORDIC table and sine/cosine word type.
package udrj_pkg;

    // Angle and CORDIC datapath width (Q.30 with headroom)
    localparam int ANG_W = 34;

    // Angle constants in Q.30
    localparam longint ANG_TWO_PI  = 64'sd6746518852;
    localparam longint ANG_PI      = 64'sd3373259426;
    localparam longint ANG_HALF_PI = 64'sd1686629713;
    localparam longint CORDIC_X0   = 64'sd652032874;

    typedef logic signed [ANG_W-1:0] ang_t;

    // Cosine and sine pair in Q.30
    typedef struct packed {
        ang_t cos_v;
        ang_t sin_v;
    } trig_t;

    // Return atan(2^-i) in Q.30; small angles use the 2^-i approximation
    function automatic ang_t atan_entry(input int i);
        ang_t v;
        v = '0;
        case (i)
            0: v = 34'sd843314857;
            1: v = 34'sd497837829;
            2: v = 34'sd263043837;
            3: v = 34'sd133525159;
            4: v = 34'sd67021687;
            5: v = 34'sd33543516;
            6: v = 34'sd16775851;
            7: v = 34'sd8388437;
            8: v = 34'sd4194283;
            9: v = 34'sd2097149;
            default: v = ang_t'(34'sd1 <<< (30 - i));
        endcase
        return v;
    endfunction

endpackage

// ----- src/udrj_sincos.sv -----
// Pipelined range reduction and rotation-mode CORDIC for sine and cosine.
module udrj_sincos #(
    parameter int FRAC_BITS  = 16,
    parameter int ITERATIONS = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [31:0]   heading,
    output udrj_pkg::trig_t      trig
);

    localparam int SH = 30 - FRAC_BITS;
    localparam int AW = 62 - FRAC_BITS;
    localparam int KS = 30 - FRAC_BITS;
    localparam logic [AW-1:0] P_W = AW'(udrj_pkg::ANG_TWO_PI);
    localparam udrj_pkg::ang_t PI_A   = udrj_pkg::ang_t'(udrj_pkg::ANG_PI);
    localparam udrj_pkg::ang_t TWOPI_A = udrj_pkg::ang_t'(udrj_pkg::ANG_TWO_PI);
    localparam udrj_pkg::ang_t HALF_A = udrj_pkg::ang_t'(udrj_pkg::ANG_HALF_PI);
    localparam udrj_pkg::ang_t X0_A   = udrj_pkg::ang_t'(udrj_pkg::CORDIC_X0);

    logic [AW-1:0]   mag_reg [0:KS];
    logic            neg_reg [0:KS];
    logic [32:0]     abs_hd;
    udrj_pkg::ang_t  r_reg, r_next;
    udrj_pkg::ang_t  z0_reg, z0_next;
    logic            flip0_reg, flip0_next;
    udrj_pkg::ang_t  x_reg [0:ITERATIONS-1];
    udrj_pkg::ang_t  y_reg [0:ITERATIONS-1];
    udrj_pkg::ang_t  z_reg [0:ITERATIONS-1];
    logic            flip_reg [0:ITERATIONS-1];
    udrj_pkg::trig_t trig_reg;

    // Take the magnitude of the scaled angle
    assign abs_hd = heading[31] ? (33'd0 - {1'b1, heading}) : {1'b0, heading};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg[0] <= {{(AW-33){1'b0}}, abs_hd} << SH;
            neg_reg[0] <= heading[31];
        end
    end

    // Remove multiples of two pi, one shifted compare and subtract per stage
    for (genvar j = 0; j < KS; j++)
    begin : g_reduce
        localparam logic [AW-1:0] STEP_W = P_W << (KS - 1 - j);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mag_reg[j+1] <= (mag_reg[j] >= STEP_W) ? (mag_reg[j] - STEP_W) : mag_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
        end
    end

    // Restore the sign and move into (-pi, pi]
    always_comb
    begin
        udrj_pkg::ang_t rem;
        rem = udrj_pkg::ang_t'({1'b0, mag_reg[KS][32:0]});
        if (neg_reg[KS] && (rem != '0))
            r_next = TWOPI_A - rem;
        else
            r_next = rem;
        if (r_next > PI_A)
            r_next = r_next - TWOPI_A;
    end

    // Fold into [-pi/2, pi/2] and mark a sign flip
    always_comb
    begin
        z0_next    = r_reg;
        flip0_next = 1'b0;
        if (r_reg > HALF_A)
        begin
            z0_next    = r_reg - PI_A;
            flip0_next = 1'b1;
        end
        else if (r_reg < -HALF_A)
        begin
            z0_next    = r_reg + PI_A;
            flip0_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg     <= r_next;
            z0_reg    <= z0_next;
            flip0_reg <= flip0_next;
        end
    end

    // Rotate one CORDIC micro-step per stage
    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_cordic
        localparam udrj_pkg::ang_t ATAN_I = udrj_pkg::atan_entry(i);
        udrj_pkg::ang_t xi, yi, zi;
        logic           fi;
        if (i == 0)
        begin : g_first
            assign xi = X0_A;
            assign yi = '0;
            assign zi = z0_reg;
            assign fi = flip0_reg;
        end
        else
        begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign fi = flip_reg[i-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!zi[udrj_pkg::ANG_W-1])
                begin
                    x_reg[i] <= xi - (yi >>> i);
                    y_reg[i] <= yi + (xi >>> i);
                    z_reg[i] <= zi - ATAN_I;
                end
                else
                begin
                    x_reg[i] <= xi + (yi >>> i);
                    y_reg[i] <= yi - (xi >>> i);
                    z_reg[i] <= zi + ATAN_I;
                end
                flip_reg[i] <= fi;
            end
        end
    end

    // Apply the half-turn fold
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig_reg.cos_v <= flip_reg[ITERATIONS-1] ? -x_reg[ITERATIONS-1]
                                                     :  x_reg[ITERATIONS-1];
            trig_reg.sin_v <= flip_reg[ITERATIONS-1] ? -y_reg[ITERATIONS-1]
                                                     :  y_reg[ITERATIONS-1];
        end
    end

    assign trig = trig_reg;

endmodule

// ----- src/unicycle_dynamics_residual_jacobian.sv -----
// Top level: unicycle Euler-step defects and Jacobian entries, fully pipelined.
// One interval word enters per cycle and one result word leaves per cycle when the
// output is not stalled; the pipeline depth is set by the two-pi reduction stages,
// one CORDIC stage per iteration and the two multiply-and-round stages. A stall on
// the output while a result word is valid freezes the whole pipeline and is passed
// back as in_stall. step_time is written through cfg_valid/cfg_ready (always
// ready) and must only change while no word is in flight.
module unicycle_dynamics_residual_jacobian #(
    parameter int FRAC_BITS         = 16,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [30:0]        step_time,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] heading,
    input  logic signed [31:0] speed,
    input  logic signed [31:0] turn_rate,
    input  logic signed [31:0] next_x,
    input  logic signed [31:0] next_y,
    input  logic signed [31:0] next_heading,
    input  logic               interval_last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] res_x,
    output logic signed [31:0] res_y,
    output logic signed [31:0] res_heading,
    output logic signed [31:0] jac_x_heading,
    output logic signed [31:0] jac_x_speed,
    output logic signed [31:0] jac_y_heading,
    output logic signed [31:0] jac_y_speed,
    output logic signed [31:0] jac_heading_rate,
    output logic               result_last
);

    localparam int LAT = (30 - FRAC_BITS) + CORDIC_ITERATIONS + 4;

    typedef struct packed {
        logic signed [32:0] dnx;
        logic signed [32:0] dny;
        logic signed [32:0] dnh;
        logic signed [31:0] sp;
        logic signed [31:0] tr;
        logic               last;
    } side_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -68'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    logic               en;
    logic [30:0]        dt_reg;
    logic signed [31:0] dt_s;
    udrj_pkg::trig_t    trig;
    side_t              side_reg [0:LAT-1];
    logic               vld_reg  [0:LAT-1];

    side_t              s1_reg, s2_reg, s3_reg, s4_reg;
    logic               v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic signed [65:0] pc_reg, ps_reg;
    logic signed [63:0] pth_reg;
    logic signed [66:0] rc_sum, rs_sum;
    logic signed [64:0] th_sum;
    logic signed [33:0] dtc_next, dts_next;
    logic signed [33:0] dtc2_reg, dts2_reg, dtc3_reg, dts3_reg, dtc4_reg, dts4_reg;
    logic signed [64:0] th2_reg, th3_reg, th4_reg;
    logic signed [65:0] ptc_reg, pts_reg;
    logic signed [66:0] tc_sum, ts_sum;
    logic signed [66:0] tc4_reg, ts4_reg;
    logic signed [31:0] rx_reg, ry_reg, rh_reg, jxh_reg, jxs_reg, jyh_reg, jys_reg;
    logic signed [31:0] jhr_reg;
    logic               last_reg;

    // Freeze everything while a finished word waits
    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;
    assign dt_s      = $signed({1'b0, dt_reg});

    // Hold the step time register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dt_reg <= 31'd6554;
        else if (cfg_valid)
            dt_reg <= step_time;
    end

    udrj_sincos #(
        .FRAC_BITS  (FRAC_BITS),
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_sincos (
        .clk     (clk),
        .en      (en),
        .heading (heading),
        .trig    (trig)
    );

    // Carry side data and valid alongside the sine/cosine pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0].dnx  <= 33'(next_x) - 33'(pos_x);
            side_reg[0].dny  <= 33'(next_y) - 33'(pos_y);
            side_reg[0].dnh  <= 33'(next_heading) - 33'(heading);
            side_reg[0].sp   <= speed;
            side_reg[0].tr   <= turn_rate;
            side_reg[0].last <= interval_last;
            for (int k = 1; k < LAT; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
            v1_reg        <= vld_reg[LAT-1];
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    // Round products back to Q.F with round half up
    assign rc_sum   = {pc_reg[65], pc_reg} + 67'sd536870912;
    assign rs_sum   = {ps_reg[65], ps_reg} + 67'sd536870912;
    assign dtc_next = rc_sum[63:30];
    assign dts_next = rs_sum[63:30];
    assign th_sum   = {pth_reg[63], pth_reg} + (65'sd1 <<< (FRAC_BITS - 1));
    assign tc_sum   = {ptc_reg[65], ptc_reg} + (67'sd1 <<< (FRAC_BITS - 1));
    assign ts_sum   = {pts_reg[65], pts_reg} + (67'sd1 <<< (FRAC_BITS - 1));

    // Advance the multiply, round and saturate stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pc_reg   <= dt_s * trig.cos_v;
            ps_reg   <= dt_s * trig.sin_v;
            pth_reg  <= dt_s * side_reg[LAT-1].tr;
            s1_reg   <= side_reg[LAT-1];

            dtc2_reg <= dtc_next;
            dts2_reg <= dts_next;
            th2_reg  <= th_sum >>> FRAC_BITS;
            s2_reg   <= s1_reg;

            ptc_reg  <= dtc2_reg * s2_reg.sp;
            pts_reg  <= dts2_reg * s2_reg.sp;
            dtc3_reg <= dtc2_reg;
            dts3_reg <= dts2_reg;
            th3_reg  <= th2_reg;
            s3_reg   <= s2_reg;

            tc4_reg  <= tc_sum >>> FRAC_BITS;
            ts4_reg  <= ts_sum >>> FRAC_BITS;
            dtc4_reg <= dtc3_reg;
            dts4_reg <= dts3_reg;
            th4_reg  <= th3_reg;
            s4_reg   <= s3_reg;

            rx_reg   <= sat32(68'(s4_reg.dnx) - 68'(tc4_reg));
            ry_reg   <= sat32(68'(s4_reg.dny) - 68'(ts4_reg));
            rh_reg   <= sat32(68'(s4_reg.dnh) - 68'(th4_reg));
            jxh_reg  <= sat32(68'(ts4_reg));
            jxs_reg  <= sat32(-68'(dtc4_reg));
            jyh_reg  <= sat32(-68'(tc4_reg));
            jys_reg  <= sat32(-68'(dts4_reg));
            jhr_reg  <= -dt_s;
            last_reg <= s4_reg.last;
        end
    end

    assign out_valid        = out_valid_reg;
    assign res_x            = rx_reg;
    assign res_y            = ry_reg;
    assign res_heading      = rh_reg;
    assign jac_x_heading    = jxh_reg;
    assign jac_x_speed      = jxs_reg;
    assign jac_y_heading    = jyh_reg;
    assign jac_y_speed      = jys_reg;
    assign jac_heading_rate = jhr_reg;
    assign result_last      = last_reg;

    // Step-time entry of a delivered word matches the negated register
    a_dt_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (jac_heading_rate == -dt_s))
        else $error("jac_heading_rate does not match step time");

    // CORDIC outputs stay within unit magnitude plus small gain error
    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAT-1] |-> (trig.cos_v <= 34'sd1074790400 && trig.cos_v >= -34'sd1074790400
                         && trig.sin_v <= 34'sd1074790400 && trig.sin_v >= -34'sd1074790400))
        else $error("sine or cosine out of range");

    // A stalled word stays valid on the next cycle
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(res_x) && $stable(result_last)))
        else $error("stalled result word changed");

endmodule
